[hw/rtl/cbe_pkg.sv]
package cbe_pkg;

    typedef enum logic [2:0] {
        MUL_IDLE,
        MUL_RUN,
        MUL_DONE
    } t_mul_state;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_C_UT,
        ST_C_B1,
        ST_C_B2,
        ST_C_TT,
        ST_C_B3,
        ST_C_M1,
        ST_C_M2,
        ST_C_SUM,
        ST_D_UU,
        ST_D_A,
        ST_D_B,
        ST_D_TT,
        ST_D_C,
        ST_D_SUM,
        ST_DIV,
        ST_UPD,
        ST_OUT
    } t_state;

endpackage

[hw/rtl/cubic_bezier_easing_eval_top.sv]
// A curve pass is 7 serial multiplies followed by a sum step; a Newton step adds 6 multiplies,
// a divide setup step and a bit-serial divide. Up to MAX_ITERATIONS Newton steps run,
// then a final y pass; busy is high from accept until o_valid.
// One transaction at a time; result shown for one cycle on o_valid; the receiver cannot stall.
// Reset (synchronous, active low) loads the control point defaults and idles.
module cubic_bezier_easing_eval_top #(
    parameter int FRAC_BITS      = 24,
    parameter int MAX_ITERATIONS = 20
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [FRAC_BITS:0] i_x_in,
    output logic               o_valid,
    output logic [FRAC_BITS:0] o_y_out,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [FRAC_BITS:0] i_cfg_data
);
    import cbe_pkg::*;

    localparam int W   = FRAC_BITS + 1;
    localparam int SW  = FRAC_BITS + 5;
    localparam int IW  = $clog2(MAX_ITERATIONS + 1);
    localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;
    localparam longint TOLV = ((longint'(1) << FRAC_BITS) + 999999) / 1000000;
    localparam logic [SW-1:0] TOL = SW'(TOLV);

    logic [W-1:0] r_c1x, r_c1y, r_c2x, r_c2y;
    t_state       r_st, n_st;
    logic [W-1:0] r_tgt, n_tgt, r_t, n_t;
    logic [W:0]   r_tmp, n_tmp, r_tmp2, n_tmp2;
    logic signed [SW-1:0] r_acc, n_acc;
    logic signed [SW-1:0] r_err, n_err;
    logic [IW-1:0] r_it, n_it;
    logic         r_fin, n_fin;
    logic         r_ms, n_ms;
    logic         r_pend, n_pend;
    logic         r_ds, n_ds;
    logic [W-1:0] n_ma, n_mb, r_ma, r_mb;
    logic [W-1:0] r_y, n_y;
    logic         r_ov, n_ov;
    logic         w_mdone, w_ddone;
    logic [W:0]   w_mp;
    logic [W:0]   w_dq;
    logic [W-1:0] w_u, w_p1, w_p2, w_d21m;
    logic         w_dneg;
    logic [SW-1:0] w_aerr, w_adx;
    logic [W-1:0] w_mpw;

    function automatic logic [W-1:0] sat1(input logic [W-1:0] v);
        sat1 = (v > ONE) ? ONE : v;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1x <= W'((2 * (longint'(1) << FRAC_BITS) + 2) / 5);
            r_c1y <= W'(((longint'(1) << FRAC_BITS) + 5) / 10);
            r_c2x <= ONE >> 1;
            r_c2y <= ONE >> 1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                2'd0: r_c1x <= i_cfg_data;
                2'd1: r_c1y <= i_cfg_data;
                2'd2: r_c2x <= i_cfg_data;
                default: r_c2y <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_IDLE;
            r_ms   <= 1'b0;
            r_pend <= 1'b0;
            r_ds   <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_ms   <= n_ms;
            r_pend <= n_pend;
            r_ds   <= n_ds;
            r_ov   <= n_ov;
        end
        r_tgt  <= n_tgt;
        r_t    <= n_t;
        r_tmp  <= n_tmp;
        r_tmp2 <= n_tmp2;
        r_acc  <= n_acc;
        r_err  <= n_err;
        r_it   <= n_it;
        r_fin  <= n_fin;
        r_ma   <= n_ma;
        r_mb   <= n_mb;
        r_y    <= n_y;
    end

    cbe_serial_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_ms),
        .i_a(r_ma), .i_b(r_mb), .o_done(w_mdone), .o_p(w_mp)
    );

    cbe_serial_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_ds),
        .i_n(w_aerr[SW-2:0]), .i_d(w_adx[SW-2:0]), .o_done(w_ddone), .o_q(w_dq)
    );

    assign w_u    = ONE - r_t;
    assign w_p1   = r_fin ? sat1(r_c1y) : sat1(r_c1x);
    assign w_p2   = r_fin ? sat1(r_c2y) : sat1(r_c2x);
    assign w_dneg = sat1(r_c1x) > sat1(r_c2x);
    assign w_d21m = w_dneg ? sat1(r_c1x) - sat1(r_c2x) : sat1(r_c2x) - sat1(r_c1x);
    assign w_aerr = r_err[SW-1] ? SW'(-r_err) : SW'(r_err);
    assign w_adx  = r_acc[SW-1] ? SW'(-r_acc) : SW'(r_acc);
    assign w_mpw  = w_mp[W-1:0];

    always_comb begin
        n_st   = r_st;
        n_tgt  = r_tgt;
        n_t    = r_t;
        n_tmp  = r_tmp;
        n_tmp2 = r_tmp2;
        n_acc  = r_acc;
        n_err  = r_err;
        n_it   = r_it;
        n_fin  = r_fin;
        n_ms   = 1'b0;
        n_pend = r_pend;
        n_ds   = 1'b0;
        n_ma   = r_ma;
        n_mb   = r_mb;
        n_y    = r_y;
        n_ov   = 1'b0;
        if (r_pend && w_mdone) n_pend = 1'b0;
        unique case (r_st)
            ST_IDLE: begin
                if (start) begin
                    n_tgt = sat1(i_x_in);
                    n_t   = sat1(i_x_in);
                    n_it  = '0;
                    n_fin = 1'b0;
                    n_ma  = ONE - sat1(i_x_in);
                    n_mb  = sat1(i_x_in);
                    n_ms  = 1'b1;
                    n_pend = 1'b1;
                    n_st  = ST_C_UT;
                end
            end
            ST_C_UT: if (w_mdone) begin
                n_tmp = w_mp;
                n_ma = w_mpw; n_mb = w_u; n_ms = 1'b1; n_pend = 1'b1;
                n_st = ST_C_B1;
            end
            ST_C_B1: if (w_mdone) begin
                n_tmp2 = w_mp;
                n_ma = r_tmp[W-1:0]; n_mb = r_t; n_ms = 1'b1; n_pend = 1'b1;
                n_st = ST_C_B2;
            end
            ST_C_B2: if (w_mdone) begin
                n_tmp = w_mp;
                n_ma = r_t; n_mb = r_t; n_ms = 1'b1; n_pend = 1'b1;
                n_st = ST_C_TT;
            end
            ST_C_TT: if (w_mdone) begin
                n_ma = w_mpw; n_mb = r_t; n_ms = 1'b1; n_pend = 1'b1;
                n_st = ST_C_B3;
            end
            ST_C_B3: if (w_mdone) begin
                n_acc = SW'(w_mp);
                n_ma = r_tmp2[W-1:0]; n_mb = w_p1; n_ms = 1'b1; n_pend = 1'b1;
                n_st = ST_C_M1;
            end
            ST_C_M1: if (w_mdone) begin
                n_acc = r_acc + SW'(3) * SW'(w_mp);
                n_ma = r_tmp[W-1:0]; n_mb = w_p2; n_ms = 1'b1; n_pend = 1'b1;
                n_st = ST_C_M2;
            end
            ST_C_M2: if (w_mdone) begin
                n_acc = r_acc + SW'(3) * SW'(w_mp);
                n_st = ST_C_SUM;
            end
            ST_C_SUM: begin
                if (r_fin) begin
                    n_y  = (r_acc > SW'(ONE)) ? ONE : r_acc[W-1:0];
                    n_ov = 1'b1;
                    n_st = ST_IDLE;
                end else begin
                    n_err = r_acc - SW'(r_tgt);
                    if ((n_err[SW-1] ? -n_err : n_err) < TOL
                        || r_it == IW'(MAX_ITERATIONS)) begin
                        n_fin = 1'b1;
                        n_ma = ONE - r_t; n_mb = r_t; n_ms = 1'b1; n_pend = 1'b1;
                        n_st = ST_C_UT;
                    end else begin
                        n_ma = w_u; n_mb = w_u; n_ms = 1'b1; n_pend = 1'b1;
                        n_st = ST_D_UU;
                    end
                end
            end
            ST_D_UU: if (w_mdone) begin
                n_ma = w_mpw; n_mb = w_p1; n_ms = 1'b1; n_pend = 1'b1;
                n_st = ST_D_A;
            end
            ST_D_A: if (w_mdone) begin
                n_acc = SW'(3) * SW'(w_mp);
                n_ma = w_u; n_mb = r_t; n_ms = 1'b1; n_pend = 1'b1;
                n_st = ST_D_B;
            end
            ST_D_B: if (w_mdone) begin
                n_ma = w_mpw; n_mb = w_d21m; n_ms = 1'b1; n_pend = 1'b1;
                n_st = ST_D_TT;
            end
            ST_D_TT: if (w_mdone) begin
                if (w_dneg) n_acc = r_acc - SW'(6) * SW'(w_mp);
                else        n_acc = r_acc + SW'(6) * SW'(w_mp);
                n_ma = r_t; n_mb = r_t; n_ms = 1'b1; n_pend = 1'b1;
                n_st = ST_D_C;
            end
            ST_D_C: if (w_mdone) begin
                n_ma = w_mpw; n_mb = ONE - sat1(r_c2x); n_ms = 1'b1; n_pend = 1'b1;
                n_st = ST_D_SUM;
            end
            ST_D_SUM: if (w_mdone) begin
                n_acc = r_acc + SW'(3) * SW'(w_mp);
                n_st = ST_DIV;
            end
            ST_DIV: begin
                n_it = r_it + 1'b1;
                if (r_acc == '0) begin
                    n_t = r_err[SW-1] ? ONE : '0;
                    n_ma = ONE - n_t; n_mb = n_t; n_ms = 1'b1; n_pend = 1'b1;
                    n_st = ST_C_UT;
                end else begin
                    n_ds = 1'b1;
                    n_st = ST_UPD;
                end
            end
            ST_UPD: if (w_ddone) begin
                if (r_err[SW-1] == r_acc[SW-1]) begin
                    n_t = ((W + 1)'(r_t) <= w_dq) ? '0 : r_t - w_dq[W-1:0];
                end else begin
                    n_t = ((W + 1)'(r_t) + w_dq > (W + 1)'(ONE)) ? ONE
                        : r_t + w_dq[W-1:0];
                end
                n_ma = ONE - n_t; n_mb = n_t; n_ms = 1'b1; n_pend = 1'b1;
                n_st = ST_C_UT;
            end
            default: n_st = ST_IDLE;
        endcase
    end

    assign busy    = (r_st != ST_IDLE);
    assign o_valid = r_ov;
    assign o_y_out = r_y;
endmodule

[hw/rtl/cbe_serial_mul.sv]
module cbe_serial_mul #(
    parameter int FRAC_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [FRAC_BITS:0]   i_a,
    input  logic [FRAC_BITS:0]   i_b,
    output logic                 o_done,
    output logic [FRAC_BITS+1:0] o_p
);
    import cbe_pkg::*;

    localparam int W  = FRAC_BITS + 1;
    localparam int PW = 2 * W;
    localparam int CW = $clog2(W + 1);

    logic [PW-1:0] r_acc, n_acc;
    logic [PW-1:0] r_mcd, n_mcd;
    logic [W-1:0]  r_mpr, n_mpr;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [PW:0]   w_rnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_acc <= n_acc;
        r_mcd <= n_mcd;
        r_mpr <= n_mpr;
        r_cnt <= n_cnt;
    end

    always_comb begin
        n_acc  = r_acc;
        n_mcd  = r_mcd;
        n_mpr  = r_mpr;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_acc  = '0;
            n_mcd  = PW'(i_a);
            n_mpr  = i_b;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_mpr[0]) n_acc = r_acc + r_mcd;
            n_mcd = r_mcd << 1;
            n_mpr = r_mpr >> 1;
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CW'(W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    assign w_rnd  = {1'b0, r_acc} + ((PW + 1)'(1) << (FRAC_BITS - 1));
    assign o_p    = w_rnd[FRAC_BITS +: W + 1];
    assign o_done = r_done;
endmodule

[hw/rtl/cbe_serial_div.sv]
module cbe_serial_div #(
    parameter int FRAC_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [FRAC_BITS+3:0] i_n,
    input  logic [FRAC_BITS+3:0] i_d,
    output logic                 o_done,
    output logic [FRAC_BITS+1:0] o_q
);
    import cbe_pkg::*;

    localparam int DW = FRAC_BITS + 4;
    localparam int NB = DW + FRAC_BITS;
    localparam int CW = $clog2(NB + 1);
    localparam int QW = FRAC_BITS + 2;

    logic [NB-1:0] r_num, n_num;
    logic [DW:0]   r_rem, n_rem;
    logic [NB-1:0] r_q, n_q;
    logic [DW-1:0] r_d, n_d;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [DW:0]   w_sh;
    logic [NB-1:0] w_cap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_num <= n_num;
        r_rem <= n_rem;
        r_q   <= n_q;
        r_d   <= n_d;
        r_cnt <= n_cnt;
    end

    assign w_sh = {r_rem[DW-1:0], r_num[NB-1]};

    always_comb begin
        n_num  = r_num;
        n_rem  = r_rem;
        n_q    = r_q;
        n_d    = r_d;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_num  = {i_n, FRAC_BITS'(0)};
            n_rem  = '0;
            n_q    = '0;
            n_d    = i_d;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_num = r_num << 1;
            if (w_sh >= {1'b0, r_d}) begin
                n_rem = w_sh - {1'b0, r_d};
                n_q   = {r_q[NB-2:0], 1'b1};
            end else begin
                n_rem = w_sh;
                n_q   = {r_q[NB-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CW'(NB - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    assign w_cap = NB'(1) << (FRAC_BITS + 1);
    assign o_q   = (r_q >= w_cap) ? QW'(w_cap) : r_q[QW-1:0];
    assign o_done = r_done;
endmodule

[bench/cubic_bezier_easing_eval_top_test.sv]
module cubic_bezier_easing_eval_top_test;

    localparam int FB = 24;
    localparam logic [FB:0] ONE_Q = 25'd16777216;
    localparam longint TOLQ = (64'd16777216 + 64'd999999) / 64'd1000000;
    localparam int MAX_STEPS = 20;
    localparam int N_RANDOM = 560;

    localparam logic [1:0] REG_P1X = 2'd0;
    localparam logic [1:0] REG_P1Y = 2'd1;
    localparam logic [1:0] REG_P2X = 2'd2;
    localparam logic [1:0] REG_P2Y = 2'd3;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    logic [FB:0] i_x_in;
    logic o_valid;
    logic [FB:0] o_y_out;
    logic i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [FB:0] i_cfg_data;

    cubic_bezier_easing_eval_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_x_in(i_x_in), .o_valid(o_valid), .o_y_out(o_y_out),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    logic [FB:0] p1x_r, p1y_r, p2x_r, p2y_r;
    logic [FB:0] y_pending[$];
    int errors;
    int n_sent;
    int n_got;
    bit no_idle;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #300000000;
        $display("timeout at %0t", $time);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic longint unsigned sat1(longint unsigned v);
        return v > ONE_Q ? ONE_Q : v;
    endfunction

    function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
        longint unsigned hi, lo;
        hi = a * (b >> 16);
        lo = a * (b & 64'hFFFF) + 64'd8388608;
        return (hi + (lo >> 16)) >> (FB - 16);
    endfunction

    function automatic longint qmul_s(longint unsigned a, longint d);
        if (d < 0) return -longint'(qmul(a, -d));
        return longint'(qmul(a, d));
    endfunction

    function automatic longint unsigned qdiv(longint unsigned n, longint unsigned d);
        longint unsigned q, r;
        q = n / d;
        r = n % d;
        if (q >= 2 * ONE_Q) return 2 * ONE_Q;
        for (int i = 0; i < FB; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= d) begin
                r = r - d;
                q = q | 1;
            end
            if (q >= 2 * ONE_Q) return 2 * ONE_Q;
        end
        return q;
    endfunction

    function automatic longint unsigned bez(longint unsigned t, longint unsigned a,
                                            longint unsigned b);
        longint unsigned u, ut;
        u = ONE_Q - t;
        ut = qmul(u, t);
        return 3 * qmul(qmul(ut, u), a) + 3 * qmul(qmul(ut, t), b)
               + qmul(qmul(t, t), t);
    endfunction

    function automatic longint bez_slope(longint unsigned t, longint unsigned a,
                                         longint unsigned b);
        longint unsigned u;
        u = ONE_Q - t;
        return 3 * longint'(qmul(qmul(u, u), a))
               + 6 * qmul_s(qmul(u, t), longint'(b) - longint'(a))
               + 3 * longint'(qmul(qmul(t, t), ONE_Q - b));
    endfunction

    function automatic logic [FB:0] ease_y(logic [FB:0] x);
        longint unsigned tgt, t, q, ax, bx;
        longint e, d;
        tgt = sat1(x);
        ax = sat1(p1x_r);
        bx = sat1(p2x_r);
        t = tgt;
        for (int i = 0; i < MAX_STEPS; i++) begin
            e = longint'(bez(t, ax, bx)) - longint'(tgt);
            if ((e < 0 ? -e : e) < TOLQ) break;
            d = bez_slope(t, ax, bx);
            if (d == 0) begin
                t = e > 0 ? 0 : ONE_Q;
                continue;
            end
            q = qdiv(e < 0 ? -e : e, d < 0 ? -d : d);
            if ((e > 0) == (d > 0)) t = q >= t ? 0 : t - q;
            else t = (t + q) > ONE_Q ? ONE_Q : t + q;
        end
        return sat1(bez(t, sat1(p1y_r), sat1(p2y_r)));
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            n_got++;
            if (y_pending.size() == 0) begin
                $display("%0t: unexpected y %0d", $time, o_y_out);
                errors++;
            end else begin
                if (o_y_out !== y_pending[0]) begin
                    $display("%0t: y expected %0d actual %0d", $time, y_pending[0],
                             o_y_out);
                    errors++;
                end
                void'(y_pending.pop_front());
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [FB:0] v);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = v;
        @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            REG_P1X: p1x_r = v;
            REG_P1Y: p1y_r = v;
            REG_P2X: p2x_r = v;
            default: p2y_r = v;
        endcase
    endtask

    task automatic drain;
        while (y_pending.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    // one transaction; exp_y < 0 means use the predictor
    task automatic send_x(logic [FB:0] x, longint exp_y);
        if (!no_idle) while ($urandom_range(99) < 17) @(negedge i_clk);
        i_x_in = x;
        start = 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        y_pending.push_back(exp_y < 0 ? ease_y(x) : exp_y[FB:0]);
        n_sent++;
        @(negedge i_clk);
        start = 1'b0;
    endtask

    function automatic logic [FB:0] rnd_q(bit allow_over);
        int k;
        k = $urandom_range(9);
        if (k == 0) return 0;
        if (k == 1) return ONE_Q;
        if (k == 2 && allow_over) return ONE_Q + (FB + 1)'($urandom_range(24'hFFFFFF));
        if (k == 3) return (FB + 1)'($urandom_range(40));
        if (k == 4) return ONE_Q - (FB + 1)'($urandom_range(40));
        return (FB + 1)'($urandom_range(ONE_Q));
    endfunction

    typedef struct {
        logic [FB:0] x;
        longint y;
    } x_row_t;

    x_row_t dir_rows[] = '{
        '{25'd0, 0}, '{ONE_Q, ONE_Q}, '{25'h1FFFFFF, ONE_Q}, '{ONE_Q + 1, ONE_Q},
        '{25'd1, -1}, '{ONE_Q - 1, -1}, '{25'd8388608, -1}, '{25'd4194304, -1},
        '{25'd12582912, -1}, '{25'h0AAAAAA, -1}, '{25'h1555555, -1}, '{25'd17, -1}
    };

    initial begin
        errors = 0;
        n_sent = 0;
        n_got = 0;
        no_idle = 0;
        start = 1'b0;
        i_x_in = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_P1X;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        p1x_r = (2 * ONE_Q + 2) / 5;
        p1y_r = (ONE_Q + 5) / 10;
        p2x_r = ONE_Q / 2;
        p2y_r = ONE_Q / 2;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i]) send_x(dir_rows[i].x, dir_rows[i].y);
        drain();

        // extreme control points: zero slope at ends, linear, overrange
        write_reg(REG_P1X, 0); write_reg(REG_P1Y, 0);
        write_reg(REG_P2X, ONE_Q); write_reg(REG_P2Y, ONE_Q);
        send_x(0, 0); send_x(ONE_Q, ONE_Q); send_x(25'd3000000, -1);
        drain();
        write_reg(REG_P1X, ONE_Q); write_reg(REG_P1Y, 25'h1FFFFFF);
        write_reg(REG_P2X, 0); write_reg(REG_P2Y, 0);
        send_x(25'd8388608, -1); send_x(25'd100, -1); send_x(ONE_Q - 100, -1);
        drain();
        write_reg(REG_P1X, 25'h1FFFFFF); write_reg(REG_P2X, 25'h1FFFFFF);
        send_x(25'd5000000, -1);
        drain();

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 40 == 0) begin
                drain();
                write_reg(REG_P1X, rnd_q(1));
                write_reg(REG_P1Y, rnd_q(1));
                write_reg(REG_P2X, rnd_q(1));
                write_reg(REG_P2Y, rnd_q(1));
            end
            no_idle = (i >= 200 && i < 280);
            if ($urandom_range(19) == 0) send_x((FB + 1)'($urandom()), -1);
            else send_x(rnd_q(1), -1);
        end
        drain();
        $display("sent %0d x values, checked %0d y values across random control points",
                 n_sent, n_got);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
